@@ design/cdeq_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types for the circular deque core.
package cdeq_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int DATA_W    = 32;
    localparam int CAP_W     = 11;
    localparam int OP_W      = 3;
    localparam int STAT_W    = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 80;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);
    localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(2);

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_DATA
    } state_t;

endpackage

@@ design/cdeq_ram.sv @@
`timescale 1ns / 1ps
// Generic RAM: one write port, two registered read ports.
module cdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ design/circular_double_ended_queue_core.sv @@
`timescale 1ns / 1ps
// Circular deque core: top level with control, indices and slot memory.
//
// Each input word (op, value) produces exactly one output word describing the
// deque after the operation. One word is processed at a time. The word is
// captured at acceptance, and its result reaches the output register in order
// through index update with slot write, read of the new front and rear slots,
// and result load. A new word is accepted only after the previous word's result
// load. The slot memory is read only after the write of the same operation has
// landed, so the front and rear read returns the value just written.
// A finished result waits in the output register while the next word is
// accepted; an unread result stalls the following word at its result load.
// Writing the capacity register empties the deque; the slot memory needs no
// clearing pass after reset.
module circular_double_ended_queue_core #(
    parameter int DEPTH = cdeq_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // s_tdata: op[2:0], value[34:3], zero pad[39:35]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cdeq_pkg::S_TDATA_W-1:0]      s_tdata,
    // m_tdata: status[1:0], front_value[33:2], rear_value[65:34],
    //          is_empty[66], is_full[67], count[78:68], zero pad[79]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cdeq_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cdeq_pkg::PADDR_W-1:0]        paddr,
    input  logic [cdeq_pkg::PDATA_W-1:0]        pwdata,
    output logic [cdeq_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_W = cdeq_pkg::CAP_W;
    localparam int DW    = cdeq_pkg::DATA_W;
    localparam int XW    = ((AW > CAP_W) ? AW : CAP_W) + 1;

    cdeq_pkg::state_t state_reg, state_next;

    logic [cdeq_pkg::OP_W-1:0]   op_reg;
    logic [DW-1:0]               value_reg;
    logic [CAP_W-1:0]            cap_reg;
    logic [AW-1:0]               head_reg, head_next;
    logic [AW-1:0]               tail_reg, tail_next;
    logic                        empty_reg, empty_next;
    logic [CAP_W-1:0]            count_reg, count_next;
    logic [cdeq_pkg::STAT_W-1:0] status_reg, status_next;

    logic                        m_tvalid_reg;
    logic [cdeq_pkg::STAT_W-1:0] out_status_reg;
    logic [DW-1:0]               out_front_reg;
    logic [DW-1:0]               out_rear_reg;
    logic                        out_empty_reg;
    logic                        out_full_reg;
    logic [CAP_W-1:0]            out_count_reg;

    logic             cfg_write;
    logic             in_accept;
    logic             exec_en;
    logic             load_out;
    logic [CAP_W-1:0] cap_eff;
    logic [XW-1:0]    cap_x;
    logic [AW-1:0]    cap_last;
    logic [AW-1:0]    head_inc, head_dec, tail_inc, tail_dec;
    logic             is_full_now;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [DW-1:0]  rdata_front;
    logic [DW-1:0]  rdata_rear;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == cdeq_pkg::REG_CAPACITY);
    assign prdata    = (paddr[2] == cdeq_pkg::REG_CAPACITY) ?
                       cdeq_pkg::PDATA_W'(cap_reg) : '0;

    // capacity in effect, saturated into [2, DEPTH]
    always_comb
    begin
        cap_eff = cap_reg;
        if (cap_reg < cdeq_pkg::CAP_MIN)
        begin
            cap_eff = cdeq_pkg::CAP_MIN;
        end
        else if (32'(cap_reg) > 32'(DEPTH))
        begin
            cap_eff = CAP_W'(DEPTH);
        end
    end

    assign cap_x    = XW'(cap_eff);
    assign cap_last = AW'(cap_x - XW'(1));

    assign head_inc = ((XW'(head_reg) + XW'(1)) >= cap_x) ? '0 : AW'(XW'(head_reg) + XW'(1));
    assign head_dec = (head_reg == '0) ? cap_last : AW'(XW'(head_reg) - XW'(1));
    assign tail_inc = ((XW'(tail_reg) + XW'(1)) >= cap_x) ? '0 : AW'(XW'(tail_reg) + XW'(1));
    assign tail_dec = (tail_reg == '0) ? cap_last : AW'(XW'(tail_reg) - XW'(1));

    assign is_full_now = (count_reg >= cap_eff);

    // control FSM: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cdeq_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = cdeq_pkg::S_EXEC;
                end
            end
            cdeq_pkg::S_EXEC: state_next = cdeq_pkg::S_READ;
            cdeq_pkg::S_READ: state_next = cdeq_pkg::S_DATA;
            cdeq_pkg::S_DATA:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    state_next = cdeq_pkg::S_IDLE;
                end
            end
            default: state_next = cdeq_pkg::S_IDLE;
        endcase
    end

    // control FSM: outputs
    always_comb
    begin
        s_tready = 1'b0;
        exec_en  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            cdeq_pkg::S_IDLE: s_tready = 1'b1;
            cdeq_pkg::S_EXEC: exec_en  = 1'b1;
            cdeq_pkg::S_READ: ;
            cdeq_pkg::S_DATA: load_out = !m_tvalid_reg || m_tready;
            default: ;
        endcase
    end

    assign in_accept = s_tvalid && s_tready;

    // operation datapath
    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        count_next  = count_reg;
        status_next = cdeq_pkg::STAT_OK;
        ram_we      = 1'b0;
        ram_waddr   = head_reg;
        case (op_reg) inside
            cdeq_pkg::OP_PUSH_FRONT, cdeq_pkg::OP_PUSH_REAR:
            begin
                if (is_full_now)
                begin
                    status_next = cdeq_pkg::STAT_OVERFLOW;
                end
                else if (empty_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    count_next = CAP_W'(1);
                    ram_we     = 1'b1;
                    ram_waddr  = '0;
                end
                else if (op_reg == cdeq_pkg::OP_PUSH_FRONT)
                begin
                    head_next  = head_dec;
                    count_next = count_reg + CAP_W'(1);
                    ram_we     = 1'b1;
                    ram_waddr  = head_dec;
                end
                else
                begin
                    tail_next  = tail_inc;
                    count_next = count_reg + CAP_W'(1);
                    ram_we     = 1'b1;
                    ram_waddr  = tail_inc;
                end
            end
            cdeq_pkg::OP_POP_FRONT, cdeq_pkg::OP_POP_REAR:
            begin
                if (empty_reg)
                begin
                    status_next = cdeq_pkg::STAT_UNDERFLOW;
                end
                else if (head_reg == tail_reg)
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b1;
                    count_next = '0;
                end
                else if (op_reg == cdeq_pkg::OP_POP_FRONT)
                begin
                    head_next  = head_inc;
                    count_next = count_reg - CAP_W'(1);
                end
                else
                begin
                    tail_next  = tail_dec;
                    count_next = count_reg - CAP_W'(1);
                end
            end
            default: ;
        endcase
        if (!exec_en)
        begin
            ram_we = 1'b0;
        end
    end

    cdeq_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (value_reg),
        .raddr_a (head_reg),
        .raddr_b (tail_reg),
        .rdata_a (rdata_front),
        .rdata_b (rdata_rear)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= cdeq_pkg::S_IDLE;
            cap_reg      <= cdeq_pkg::CAP_RESET;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                cap_reg   <= pwdata[CAP_W-1:0];
                head_reg  <= '0;
                tail_reg  <= '0;
                empty_reg <= 1'b1;
                count_reg <= '0;
            end
            else if (exec_en)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
                count_reg <= count_next;
            end
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg    <= s_tdata[cdeq_pkg::OP_W-1:0];
            value_reg <= s_tdata[cdeq_pkg::OP_W +: DW];
        end
        if (exec_en)
        begin
            status_reg <= status_next;
        end
        if (load_out)
        begin
            out_status_reg <= status_reg;
            out_front_reg  <= empty_reg ? '1 : rdata_front;
            out_rear_reg   <= empty_reg ? '1 : rdata_rear;
            out_empty_reg  <= empty_reg;
            out_full_reg   <= (count_reg == cap_eff);
            out_count_reg  <= count_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_full_reg, out_empty_reg,
                       out_rear_reg, out_front_reg, out_status_reg};

    a_count_empty: assert property (@(posedge clk) disable iff (!rst_n)
        empty_reg == (count_reg == '0))
        else $error("count and empty flag disagree");

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cap_eff)
        else $error("count exceeds capacity");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (XW'(head_reg) < cap_x) && (XW'(tail_reg) < cap_x))
        else $error("index outside capacity");

    a_load_from_data: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg) == cdeq_pkg::S_DATA)
        else $error("result loaded outside data state");

endmodule

@@ tb/sv/cdeq_check.sv @@
`timescale 1ns / 1ps
// Deque checker: mirrors the core from observed words and register writes, compares results.
module cdeq_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    // s_tdata: op, value, zero pad
    input  logic [cdeq_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: status, front_value, rear_value, is_empty, is_full, count, zero pad
    input  logic [cdeq_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cdeq_pkg::PADDR_W-1:0]     paddr,
    input  logic [cdeq_pkg::PDATA_W-1:0]     pwdata,
    input  logic [cdeq_pkg::PDATA_W-1:0]     prdata,
    input  logic                             pready,
    output int                               errors,
    output int                               pending,
    output int                               words_checked,
    output int                               overflows,
    output int                               underflows,
    output int                               full_hits
);
    import cdeq_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] front_value;
        logic [DATA_W-1:0] rear_value;
        logic              is_empty;
        logic              is_full;
        logic [CAP_W-1:0]  count;
    } deque_view_t;

    logic [DATA_W-1:0] slot_mem [DEPTH_DEF];
    int unsigned       head_idx;
    int unsigned       tail_idx;
    bit                empty_q;
    logic [CAP_W-1:0]  cap_reg;
    deque_view_t       views_q [$];
    int                n_err;
    int                n_words;
    int                n_ovf;
    int                n_udf;
    int                n_full;

    function automatic int unsigned cap_in_use();
        if (cap_reg < CAP_MIN)
            return CAP_MIN;
        if (cap_reg > DEPTH_DEF)
            return DEPTH_DEF;
        return cap_reg;
    endfunction

    function automatic int unsigned held();
        int unsigned c;
        c = cap_in_use();
        if (empty_q)
            return 0;
        if (tail_idx >= head_idx)
            return tail_idx - head_idx + 1;
        return tail_idx + c - head_idx + 1;
    endfunction

    function automatic deque_view_t step_deque(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
        deque_view_t v;
        int unsigned c;
        int unsigned n;
        c = cap_in_use();
        n = held();
        v.status = STAT_OK;
        if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
            if (n >= c) begin
                v.status = STAT_OVERFLOW;
            end else if (empty_q) begin
                head_idx    = 0;
                tail_idx    = 0;
                empty_q     = 1'b0;
                slot_mem[0] = val;
            end else if (op == OP_PUSH_FRONT) begin
                head_idx = (head_idx == 0) ? c - 1 : head_idx - 1;
                slot_mem[head_idx] = val;
            end else begin
                tail_idx = (tail_idx + 1 >= c) ? 0 : tail_idx + 1;
                slot_mem[tail_idx] = val;
            end
        end else if (op == OP_POP_FRONT || op == OP_POP_REAR) begin
            if (empty_q) begin
                v.status = STAT_UNDERFLOW;
            end else if (head_idx == tail_idx) begin
                head_idx = 0;
                tail_idx = 0;
                empty_q  = 1'b1;
            end else if (op == OP_POP_FRONT) begin
                head_idx = (head_idx + 1 >= c) ? 0 : head_idx + 1;
            end else begin
                tail_idx = (tail_idx == 0) ? c - 1 : tail_idx - 1;
            end
        end
        n = held();
        v.front_value = empty_q ? '1 : slot_mem[head_idx];
        v.rear_value  = empty_q ? '1 : slot_mem[tail_idx];
        v.is_empty    = empty_q;
        v.is_full     = (n == c);
        v.count       = CAP_W'(n);
        return v;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        deque_view_t want;
        deque_view_t got;
        if (!rst_n) begin
            head_idx = 0;
            tail_idx = 0;
            empty_q  = 1'b1;
            cap_reg  = CAP_RESET;
            views_q.delete();
            n_err    = 0;
            n_words  = 0;
            n_ovf    = 0;
            n_udf    = 0;
            n_full   = 0;
        end else begin
            if (psel && penable && pready && paddr[2] == REG_CAPACITY) begin
                if (pwrite) begin
                    cap_reg  = pwdata[CAP_W-1:0];
                    head_idx = 0;
                    tail_idx = 0;
                    empty_q  = 1'b1;
                end else if (prdata !== PDATA_W'(cap_reg)) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t capacity read: exp %0d got %0d", $time, cap_reg, prdata);
                end
            end
            if (s_tvalid && s_tready) begin
                want = step_deque(s_tdata[OP_W-1:0], s_tdata[OP_W +: DATA_W]);
                views_q.push_back(want);
                if (want.status == STAT_OVERFLOW)
                    n_ovf++;
                if (want.status == STAT_UNDERFLOW)
                    n_udf++;
                if (want.is_full)
                    n_full++;
            end
            if (m_tvalid && m_tready) begin
                got.status      = m_tdata[1:0];
                got.front_value = m_tdata[33:2];
                got.rear_value  = m_tdata[65:34];
                got.is_empty    = m_tdata[66];
                got.is_full     = m_tdata[67];
                got.count       = m_tdata[78:68];
                if (views_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("%0t result word with nothing outstanding: %h", $time, m_tdata);
                end else begin
                    want = views_q.pop_front();
                    n_words++;
                    if (got !== want) begin
                        n_err++;
                        if (n_err <= 10)
                            $display({"%0t mismatch: exp st=%0d f=%h r=%h e=%b fu=%b n=%0d",
                                      " | got st=%0d f=%h r=%h e=%b fu=%b n=%0d"}, $time,
                                     want.status, want.front_value, want.rear_value,
                                     want.is_empty, want.is_full, want.count,
                                     got.status, got.front_value, got.rear_value,
                                     got.is_empty, got.is_full, got.count);
                    end
                end
            end
        end
        errors        <= n_err;
        pending       <= views_q.size();
        words_checked <= n_words;
        overflows     <= n_ovf;
        underflows    <= n_udf;
        full_hits     <= n_full;
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for the circular deque core: stimulus, register writes and verdict.
module tb_top;
    import cdeq_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNUSED   = 3'b100;
    localparam logic [OP_W-1:0]    OP_UNDEF_A    = 3'd5;
    localparam logic [OP_W-1:0]    OP_UNDEF_B    = 3'd6;
    localparam logic [OP_W-1:0]    OP_UNDEF_C    = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    int send_idle_pct;
    int recv_stall_pct;
    int cap_settings;
    int errors;
    int pending;
    int words_checked;
    int overflows;
    int underflows;
    int full_hits;

    circular_double_ended_queue_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cdeq_check i_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .errors        (errors),
        .pending       (pending),
        .words_checked (words_checked),
        .overflows     (overflows),
        .underflows    (underflows),
        .full_hits     (full_hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_word(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'({$urandom, $urandom});
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - OP_W - DATA_W){1'b0}}, val, op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold off until every word in flight has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic apb_access(bit wr, logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] cap);
        apb_access(1'b1, ADDR_CAPACITY, PDATA_W'(cap));
        apb_access(1'b0, ADDR_CAPACITY, '0);
        cap_settings++;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 74;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 74;
            end
            default:
            begin
                send_idle_pct  = 36;
                recv_stall_pct = 36;
            end
        endcase
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h7fff_ffff;
            3: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // kind 0..3 fill run, 4..7 drain run, 8..9 noise
    function automatic logic [OP_W-1:0] pick_op(int kind);
        int r;
        logic [OP_W-1:0] push_op;
        logic [OP_W-1:0] pop_op;
        r       = $urandom_range(99);
        push_op = $urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
        pop_op  = $urandom_range(1) ? OP_POP_REAR : OP_POP_FRONT;
        if (kind < 4)
            return (r < 85) ? push_op : ((r < 95) ? pop_op : OP_READ);
        if (kind < 8)
            return (r < 85) ? pop_op : ((r < 95) ? push_op : OP_READ);
        return OP_W'($urandom_range(7));
    endfunction

    task automatic random_run(int n_items, int unsigned cap_eff);
        int left;
        int seg;
        int kind;
        left = n_items;
        while (left > 0)
        begin
            kind = $urandom_range(9);
            seg  = $urandom_range(1, 2 * cap_eff + 2);
            if (seg > left)
                seg = left;
            repeat (seg)
            begin
                send_word(pick_op(kind), pick_value());
                left--;
                if (left == n_items / 2)
                    settle();
            end
        end
    endtask

    initial
    begin : stim
        int caps [12];
        int unsigned c;
        int k;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        m_tready <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        cap_settings   = 0;
        caps = '{2, 3, 5, 0, 1, 8, 16, 2047, 33, 1500, 4, 0};
        caps[11] = $urandom_range(2, 64);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty deque at reset capacity, odd ops, pushes at both ends
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_REAR, '1);
        send_word(OP_READ, 32'h1234_5678);
        send_word(OP_UNDEF_A, 32'hdead_beef);
        send_word(OP_UNDEF_C, '1);
        send_word(OP_PUSH_REAR, 32'h7fff_ffff);
        send_word(OP_PUSH_FRONT, 32'h8000_0000);
        send_word(OP_PUSH_REAR, '0);
        send_word(OP_PUSH_FRONT, '1);
        send_word(OP_UNDEF_B, 32'h5555_aaaa);
        settle();
        apb_access(1'b1, ADDR_UNUSED, '1);
        send_word(OP_READ, '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_REAR, '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_REAR, '0);
        send_word(OP_POP_REAR, '0);
        settle();

        // smallest capacity: wrap, full, overflow on both ends
        set_capacity(CAP_MIN);
        send_word(OP_PUSH_FRONT, 32'h0000_0005);
        send_word(OP_PUSH_FRONT, 32'h0000_0006);
        send_word(OP_PUSH_REAR, 32'h0000_0007);
        send_word(OP_PUSH_FRONT, 32'h0000_0008);
        send_word(OP_POP_REAR, '0);
        send_word(OP_PUSH_REAR, 32'h0000_0009);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_POP_FRONT, '0);
        send_word(OP_READ, '0);

        for (k = 0; k < 12; k++)
        begin
            settle();
            set_capacity(CAP_W'(caps[k]));
            set_idling(k % 4);
            c = (caps[k] < CAP_MIN) ? CAP_MIN : ((caps[k] > DEPTH_DEF) ? DEPTH_DEF : caps[k]);
            random_run(16, c);
        end

        // full-size deque filled to the top, then worked at both ends
        settle();
        set_capacity(CAP_RESET);
        set_idling(3);
        repeat (DEPTH_DEF + 4)
            send_word($urandom_range(1) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_value());
        repeat (20)
            send_word(pick_op($urandom_range(9)), pick_value());
        settle();
        set_capacity('1);
        set_idling(0);
        random_run(20, DEPTH_DEF);

        s_tvalid <= 1'b0;
        @(posedge clk);
        for (k = 0; k < 4000 && pending != 0; k++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("tb_top: %0d result words checked across %0d capacity settings",
                 words_checked, cap_settings);
        $display("tb_top: %0d overflows, %0d underflows, %0d full results",
                 overflows, underflows, full_hits);
        if (errors == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
